// ----- rtl/sdrx_pkg.sv -----
// sdrx_pkg: shared types, constants and crc functions of the sd spi receive framer
// depends on nothing; used by sd_spi_receive_framer, sdrx_checker and the sim files
`timescale 1ns / 1ps

package sdrx_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned CNT_W       = $clog2(BLOCK_BYTES + 3);
  localparam int unsigned POS_W       = 10;

  localparam logic [7:0]  TOK_SINGLE = 8'hFE;
  localparam logic [7:0]  TOK_MULTI  = 8'hFC;
  localparam logic [7:0]  TOK_STOP   = 8'hFD;
  localparam logic [7:0]  TOK_IDLE   = 8'hFF;
  localparam logic [1:0]  CMD_START  = 2'b01;
  localparam logic [6:0]  CRC7_POLY  = 7'h09;
  localparam logic [15:0] CRC16_POLY = 16'h1021;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_SINGLE = 2'd1,
    OP_MULTI  = 2'd2,
    OP_CMD    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CMD   = 3'd1,
    EV_DATA  = 3'd2,
    EV_BLOCK = 3'd3,
    EV_STOP  = 3'd4,
    EV_BAD   = 3'd5
  } ev_e;

  localparam logic [CNT_W-1:0] CNT_LAST_DATA = CNT_W'(BLOCK_BYTES);
  localparam logic [CNT_W-1:0] CNT_CRC_HI    = CNT_W'(BLOCK_BYTES + 1);
  localparam logic [POS_W-1:0] POS_CRC_HI    = POS_W'(BLOCK_BYTES);
  localparam logic [POS_W-1:0] POS_CRC_LO    = POS_W'(BLOCK_BYTES + 1);

  function automatic logic [6:0] crc7_byte(logic [6:0] c, logic [7:0] b);
    logic [6:0] r;
    logic       fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[6] ^ b[i];
      r  = {r[5:0], 1'b0};
      if (fb) begin
        r = r ^ CRC7_POLY;
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC16_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] cnt_to_pos(logic [CNT_W-1:0] cnt);
    logic [CNT_W+POS_W-1:0] w;
    w = {{POS_W{1'b0}}, cnt};
    return w[POS_W-1:0];
  endfunction

endpackage

// ----- rtl/sd_spi_receive_framer.sv -----
// sd_spi_receive_framer: sd card spi mode receive framer, command frames and data blocks
// depends on sdrx_pkg
//
//  channel   direction  handshake                 payload
//  in        to block   in_valid_i / in_stall_o   op_i, mosi_i
//  out       from block out_valid_o / out_stall_i event_kind_o .. byte_value_o
//  cfg       to block   cfg_valid_i / cfg_ready_o cfg_wdata_i (crc check enable)
//
// one result per request, one request per cycle sustained while out_stall_i is low;
// each request passes the input register, then crc/frame logic into the result register
// reset clears mode, counter and crc enable; no clearing pass
// out_stall_i holds the result register and stalls the input when both stages are full
`timescale 1ns / 1ps

module sd_spi_receive_framer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                op_i,
  input  logic [7:0]                mosi_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                event_kind_o,
  output logic [5:0]                cmd_index_o,
  output logic [31:0]               cmd_arg_o,
  output logic                      check_ok_o,
  output logic [sdrx_pkg::POS_W-1:0] byte_pos_o,
  output logic [7:0]                byte_value_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_wdata_i
);

  logic                        s1_valid_q;
  logic [1:0]                  s1_op_q;
  logic [7:0]                  s1_mosi_q;
  logic                        out_free;
  logic                        adv;

  logic                        crc_en_q;
  logic                        data_mode_q, data_mode_d;
  logic                        multi_q, multi_d;
  logic [sdrx_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [39:0]                 frame_q, frame_d;
  logic [6:0]                  crc7_q, crc7_d;
  logic [15:0]                 crc16_q, crc16_d;
  logic [7:0]                  crc_hi_q, crc_hi_d;

  sdrx_pkg::ev_e               ev_d;
  logic [5:0]                  idx_d;
  logic [31:0]                 arg_d;
  logic                        ok_d;
  logic [sdrx_pkg::POS_W-1:0]  pos_d;
  logic [7:0]                  val_d;
  logic                        crc16_ok;
  logic                        cmd_ok;

  assign out_free    = !out_valid_o || !out_stall_i;
  assign adv         = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign cfg_ready_o = 1'b1;

  assign crc16_ok = ({crc_hi_q, s1_mosi_q} == crc16_q);
  assign cmd_ok   = s1_mosi_q[0] &&
                    (!((frame_q[37:32] == 6'd0) || crc_en_q) ||
                     (s1_mosi_q[7:1] == crc7_q));

  always_comb begin
    data_mode_d = data_mode_q;
    multi_d     = multi_q;
    cnt_d       = cnt_q;
    frame_d     = frame_q;
    crc7_d      = crc7_q;
    crc16_d     = crc16_q;
    crc_hi_d    = crc_hi_q;
    ev_d        = sdrx_pkg::EV_NONE;
    idx_d       = '0;
    arg_d       = '0;
    ok_d        = 1'b0;
    pos_d       = '0;
    val_d       = '0;
    case (sdrx_pkg::op_e'(s1_op_q))
      sdrx_pkg::OP_SINGLE, sdrx_pkg::OP_MULTI: begin
        data_mode_d = 1'b1;
        multi_d     = (s1_op_q == sdrx_pkg::OP_MULTI);
        cnt_d       = '0;
      end
      sdrx_pkg::OP_CMD: begin
        data_mode_d = 1'b0;
        cnt_d       = '0;
      end
      sdrx_pkg::OP_BYTE: begin
        if (data_mode_q) begin
          if (cnt_q == '0) begin
            if ((s1_mosi_q == sdrx_pkg::TOK_SINGLE && !multi_q) ||
                (s1_mosi_q == sdrx_pkg::TOK_MULTI && multi_q)) begin
              crc16_d = '0;
              cnt_d   = sdrx_pkg::CNT_W'(1);
            end else if (s1_mosi_q == sdrx_pkg::TOK_STOP) begin
              ev_d        = sdrx_pkg::EV_STOP;
              val_d       = s1_mosi_q;
              data_mode_d = 1'b0;
            end else if (s1_mosi_q != sdrx_pkg::TOK_IDLE) begin
              ev_d        = sdrx_pkg::EV_BAD;
              val_d       = s1_mosi_q;
              data_mode_d = 1'b0;
            end
          end else if (cnt_q <= sdrx_pkg::CNT_LAST_DATA) begin
            ev_d    = sdrx_pkg::EV_DATA;
            pos_d   = sdrx_pkg::cnt_to_pos(cnt_q - sdrx_pkg::CNT_W'(1));
            val_d   = s1_mosi_q;
            crc16_d = sdrx_pkg::crc16_byte(crc16_q, s1_mosi_q);
            cnt_d   = cnt_q + sdrx_pkg::CNT_W'(1);
          end else if (cnt_q == sdrx_pkg::CNT_CRC_HI) begin
            ev_d     = sdrx_pkg::EV_DATA;
            pos_d    = sdrx_pkg::POS_CRC_HI;
            val_d    = s1_mosi_q;
            crc_hi_d = s1_mosi_q;
            cnt_d    = cnt_q + sdrx_pkg::CNT_W'(1);
          end else begin
            ev_d  = sdrx_pkg::EV_BLOCK;
            ok_d  = crc16_ok;
            pos_d = sdrx_pkg::POS_CRC_LO;
            val_d = s1_mosi_q;
            cnt_d = '0;
            if ((crc_en_q && !crc16_ok) || !multi_q) begin
              data_mode_d = 1'b0;
            end
          end
        end else begin
          if (cnt_q == '0) begin
            if (s1_mosi_q[7:6] == sdrx_pkg::CMD_START) begin
              frame_d = {32'd0, s1_mosi_q};
              crc7_d  = sdrx_pkg::crc7_byte(7'd0, s1_mosi_q);
              cnt_d   = sdrx_pkg::CNT_W'(1);
            end
          end else if (cnt_q < sdrx_pkg::CNT_W'(5)) begin
            frame_d = {frame_q[31:0], s1_mosi_q};
            crc7_d  = sdrx_pkg::crc7_byte(crc7_q, s1_mosi_q);
            cnt_d   = cnt_q + sdrx_pkg::CNT_W'(1);
          end else if (cnt_q == sdrx_pkg::CNT_W'(5)) begin
            ev_d  = sdrx_pkg::EV_CMD;
            idx_d = frame_q[37:32];
            arg_d = frame_q[31:0];
            ok_d  = cmd_ok;
            cnt_d = '0;
          end else begin
            cnt_d = '0;
          end
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
      crc_en_q    <= 1'b0;
      data_mode_q <= 1'b0;
      multi_q     <= 1'b0;
      cnt_q       <= '0;
      frame_q     <= '0;
      crc7_q      <= '0;
      crc16_q     <= '0;
      crc_hi_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        crc_en_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_o <= adv;
      end
      if (adv) begin
        data_mode_q <= data_mode_d;
        multi_q     <= multi_d;
        cnt_q       <= cnt_d;
        frame_q     <= frame_d;
        crc7_q      <= crc7_d;
        crc16_q     <= crc16_d;
        crc_hi_q    <= crc_hi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_op_q   <= op_i;
      s1_mosi_q <= mosi_i;
    end
    if (adv) begin
      event_kind_o <= ev_d;
      cmd_index_o  <= idx_d;
      cmd_arg_o    <= arg_d;
      check_ok_o   <= ok_d;
      byte_pos_o   <= pos_d;
      byte_value_o <= val_d;
    end
  end

endmodule

// ----- rtl/sdrx_checker.sv -----
// sdrx_checker: port-level assertions for sd_spi_receive_framer, bound into each framer instance
// depends on sdrx_pkg
`timescale 1ns / 1ps

module sdrx_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [2:0]                 event_kind_o,
  input logic [5:0]                 cmd_index_o,
  input logic [31:0]                cmd_arg_o,
  input logic                       check_ok_o,
  input logic [sdrx_pkg::POS_W-1:0] byte_pos_o,
  input logic [7:0]                 byte_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o) &&
      $stable(byte_value_o))
    else $error("result dropped or changed while stalled");

  a_cmd_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != sdrx_pkg::EV_CMD |->
      cmd_index_o == 6'd0 && cmd_arg_o == 32'd0)
    else $error("command fields set on a non-command result");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == sdrx_pkg::EV_NONE |->
      !check_ok_o && byte_pos_o == '0 && byte_value_o == 8'd0)
    else $error("empty result carries data");

  a_block_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == sdrx_pkg::EV_BLOCK |->
      byte_pos_o == sdrx_pkg::POS_CRC_LO)
    else $error("block complete at wrong position");

endmodule

bind sd_spi_receive_framer sdrx_checker u_sdrx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .event_kind_o (event_kind_o),
  .cmd_index_o  (cmd_index_o),
  .cmd_arg_o    (cmd_arg_o),
  .check_ok_o   (check_ok_o),
  .byte_pos_o   (byte_pos_o),
  .byte_value_o (byte_value_o)
);

// ----- sim/sdrx_crc_pkg.sv -----
// sdrx_crc_pkg: bitwise crc7 and crc16-ccitt updates for the framer testbench
// depends on sdrx_pkg for the polynomials; used by the scoreboard and the test top
`timescale 1ns / 1ps

package sdrx_crc_pkg;

  function automatic logic [6:0] crc7_next(logic [6:0] crc, logic [7:0] data);
    logic [6:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      c = {c[5:0], 1'b0} ^ ((c[6] ^ data[i]) ? sdrx_pkg::CRC7_POLY : 7'h00);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      c = {c[14:0], 1'b0} ^ ((c[15] ^ data[i]) ? sdrx_pkg::CRC16_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

// ----- sim/sdrx_event_scoreboard.sv -----
// sdrx_event_scoreboard: watches the request, result and config channels of the framer,
// predicts each result from its own copy of the framer state and compares field by field
// depends on sdrx_pkg and sdrx_crc_pkg
`timescale 1ns / 1ps

module sdrx_event_scoreboard
  import sdrx_pkg::*;
  import sdrx_crc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       op_i,
  input  logic [7:0]       mosi_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [2:0]       event_kind_i,
  input  logic [5:0]       cmd_index_i,
  input  logic [31:0]      cmd_arg_i,
  input  logic             check_ok_i,
  input  logic [POS_W-1:0] byte_pos_i,
  input  logic [7:0]       byte_value_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic             cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o,
  output int               frames_o,
  output int               blocks_ok_o,
  output int               blocks_bad_o
);

  typedef struct packed {
    ev_e              kind;
    logic [5:0]       cmd_index;
    logic [31:0]      arg;
    logic             ok;
    logic [POS_W-1:0] pos;
    logic [7:0]       value;
  } sd_event_t;

  sd_event_t        expected_q[$];
  sd_event_t        want;
  sd_event_t        next_ev;

  logic             crc_en;
  logic             data_mode;
  logic             multi;
  logic [CNT_W-1:0] count;
  logic [39:0]      frame;
  logic [6:0]       crc7;
  logic [15:0]      crc16;
  logic [7:0]       crc_hi;

  int fail_count;
  int pending;
  int checked;
  int frames;
  int blocks_ok;
  int blocks_bad;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign frames_o     = frames;
  assign blocks_ok_o  = blocks_ok;
  assign blocks_bad_o = blocks_bad;

  task automatic report(string field, logic [31:0] exp_val, logic [31:0] got_val);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%s mismatch at result %0d: expected 0x%0h, got 0x%0h",
               field, checked, exp_val, got_val);
    end
  endtask

  task automatic predict(input op_e op, input logic [7:0] b, output sd_event_t e);
    logic [5:0] idx;
    logic       good;
    e = '{kind: EV_NONE, cmd_index: '0, arg: '0, ok: 1'b0, pos: '0, value: '0};
    case (op)
      OP_SINGLE, OP_MULTI: begin
        data_mode = 1'b1;
        multi     = (op == OP_MULTI);
        count     = '0;
      end
      OP_CMD: begin
        data_mode = 1'b0;
        count     = '0;
      end
      default: begin
        if (data_mode) begin
          if (count == 0) begin
            if ((b == TOK_SINGLE && !multi) || (b == TOK_MULTI && multi)) begin
              crc16 = '0;
              count = CNT_W'(1);
            end else if (b == TOK_STOP) begin
              e.kind    = EV_STOP;
              e.value   = b;
              data_mode = 1'b0;
              count     = '0;
            end else if (b != TOK_IDLE) begin
              e.kind    = EV_BAD;
              e.value   = b;
              data_mode = 1'b0;
              count     = '0;
            end
          end else if (count <= BLOCK_BYTES) begin
            e.kind  = EV_DATA;
            e.pos   = POS_W'(count - 1'b1);
            e.value = b;
            crc16   = crc16_next(crc16, b);
            count   = count + 1'b1;
          end else if (count == BLOCK_BYTES + 1) begin
            e.kind  = EV_DATA;
            e.pos   = POS_W'(BLOCK_BYTES);
            e.value = b;
            crc_hi  = b;
            count   = count + 1'b1;
          end else begin
            good    = ({crc_hi, b} == crc16);
            e.kind  = EV_BLOCK;
            e.ok    = good;
            e.pos   = POS_W'(BLOCK_BYTES + 1);
            e.value = b;
            // a rejected block or the end of a single block leaves data mode
            if ((crc_en && !good) || !multi) begin
              data_mode = 1'b0;
            end
            count = '0;
          end
        end else begin
          if (count == 0) begin
            if (b[7:6] == CMD_START) begin
              frame = {32'h0, b};
              crc7  = crc7_next(7'h00, b);
              count = CNT_W'(1);
            end
          end else if (count < 5) begin
            frame = {frame[31:0], b};
            crc7  = crc7_next(crc7, b);
            count = count + 1'b1;
          end else if (count == 5) begin
            idx  = frame[37:32];
            good = b[0];
            // the reset command always carries a checked crc
            if (idx == 0 || crc_en) begin
              good = good && (b[7:1] == crc7);
            end
            e.kind      = EV_CMD;
            e.cmd_index = idx;
            e.arg       = frame[31:0];
            e.ok        = good;
            count       = '0;
          end else begin
            count = '0;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      crc_en     = 1'b0;
      data_mode  = 1'b0;
      multi      = 1'b0;
      count      = '0;
      frame      = '0;
      crc7       = '0;
      crc16      = '0;
      crc_hi     = '0;
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      frames     = 0;
      blocks_ok  = 0;
      blocks_bad = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report("result with no request pending", '0, 32'(event_kind_i));
        end else begin
          want = expected_q.pop_front();
          if (event_kind_i !== want.kind) begin
            report("event_kind", 32'(want.kind), 32'(event_kind_i));
          end
          if (cmd_index_i !== want.cmd_index) begin
            report("cmd_index", 32'(want.cmd_index), 32'(cmd_index_i));
          end
          if (cmd_arg_i !== want.arg) begin
            report("cmd_arg", want.arg, cmd_arg_i);
          end
          if (check_ok_i !== want.ok) begin
            report("check_ok", 32'(want.ok), 32'(check_ok_i));
          end
          if (byte_pos_i !== want.pos) begin
            report("byte_pos", 32'(want.pos), 32'(byte_pos_i));
          end
          if (byte_value_i !== want.value) begin
            report("byte_value", 32'(want.value), 32'(byte_value_i));
          end
          checked++;
          if (want.kind == EV_CMD) begin
            frames++;
          end
          if (want.kind == EV_BLOCK) begin
            if (want.ok) begin
              blocks_ok++;
            end else begin
              blocks_bad++;
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        crc_en = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict(op_e'(op_i), mosi_i, next_ev);
        expected_q.push_back(next_ev);
      end
      pending = expected_q.size();
    end
  end

endmodule

// ----- sim/sd_spi_receive_framer_test.sv -----
// sd_spi_receive_framer_test: stimulus and verdict for the sd spi receive framer
// depends on sdrx_pkg, sdrx_crc_pkg, sdrx_event_scoreboard and sd_spi_receive_framer
`timescale 1ns / 1ps

module sd_spi_receive_framer_test;
  import sdrx_pkg::*;
  import sdrx_crc_pkg::*;

  localparam int CYCLE_LIMIT       = 1_000_000;
  localparam int PHASE_ITEMS       = 160;
  localparam int BLOCK_PHASE_ITEMS = 600;
  localparam int ABORT_MAX         = 40;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  op_e              in_op;
  logic [7:0]       in_mosi;
  logic             out_valid;
  logic             out_stall;
  logic [2:0]       event_kind;
  logic [5:0]       cmd_index;
  logic [31:0]      cmd_arg;
  logic             check_ok;
  logic [POS_W-1:0] byte_pos;
  logic [7:0]       byte_value;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_wdata;

  int  fail_count;
  int  pending;
  int  checked;
  int  frames;
  int  blocks_ok;
  int  blocks_bad;
  int  sent;
  int  blocks_sent;
  int  cycles;
  bit  crc_en;
  bit  no_gaps;

  sd_spi_receive_framer i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (in_op),
    .mosi_i       (in_mosi),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .event_kind_o (event_kind),
    .cmd_index_o  (cmd_index),
    .cmd_arg_o    (cmd_arg),
    .check_ok_o   (check_ok),
    .byte_pos_o   (byte_pos),
    .byte_value_o (byte_value),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_wdata_i  (cfg_wdata)
  );

  sdrx_event_scoreboard i_events (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (in_op),
    .mosi_i       (in_mosi),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .event_kind_i (event_kind),
    .cmd_index_i  (cmd_index),
    .cmd_arg_i    (cmd_arg),
    .check_ok_i   (check_ok),
    .byte_pos_i   (byte_pos),
    .byte_value_i (byte_value),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .frames_o     (frames),
    .blocks_ok_o  (blocks_ok),
    .blocks_bad_o (blocks_bad)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sd_spi_receive_framer regression: fail");
      $finish;
    end
  end

  // result side back-pressure: runs of acceptance broken by stalls, mostly short
  initial begin
    int run;
    int hold;
    int r;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      @(negedge clk);
      out_stall <= 1'b0;
      repeat (run - 1) @(negedge clk);
      r = $urandom_range(0, 99);
      hold = (r < 70) ? $urandom_range(1, 3) : (r < 95) ? $urandom_range(4, 8) :
             $urandom_range(15, 40);
      @(negedge clk);
      out_stall <= 1'b1;
      repeat (hold - 1) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send(op_e op, logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_mosi  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // drain every outstanding request, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_crc_check(logic en);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    crc_en = en;
  endtask

  task automatic send_frame(logic [5:0] idx, logic [31:0] arg, logic [6:0] crc_flip,
                            logic end_bit, int nbytes);
    logic [7:0] frame_b[6];
    logic [6:0] crc;
    frame_b[0] = {CMD_START, idx};
    frame_b[1] = arg[31:24];
    frame_b[2] = arg[23:16];
    frame_b[3] = arg[15:8];
    frame_b[4] = arg[7:0];
    crc = 7'h00;
    for (int i = 0; i < 5; i++) begin
      crc = crc7_next(crc, frame_b[i]);
    end
    frame_b[5] = {crc ^ crc_flip, end_bit};
    for (int i = 0; i < nbytes; i++) begin
      send(OP_BYTE, frame_b[i]);
    end
  endtask

  // token, block payload and crc; an abort position inside the block ends it early
  task automatic send_block(logic [7:0] token, logic [15:0] crc_flip, int pattern, int abort);
    logic [15:0] crc;
    logic [7:0]  d;
    send(OP_BYTE, token);
    crc = 16'h0000;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (i == abort) begin
        send(OP_CMD, 8'($urandom_range(0, 255)));
        return;
      end
      case (pattern)
        0: d = 8'($urandom_range(0, 255));
        1: d = 8'h00;
        2: d = 8'hFF;
        default: d = 8'(i);
      endcase
      crc = crc16_next(crc, d);
      send(OP_BYTE, d);
    end
    crc = crc ^ crc_flip;
    send(OP_BYTE, crc[15:8]);
    send(OP_BYTE, crc[7:0]);
    blocks_sent++;
  endtask

  // only a phase that asks for it carries one complete block, other blocks end early
  task automatic run_phase(int budget, bit want_block);
    int          n0;
    int          b0;
    int          kind;
    int          sel;
    bit          is_multi;
    bit          live;
    int          nblk;
    int          abort;
    logic [15:0] flip16;
    logic [6:0]  flip7;
    logic [5:0]  idx;
    logic [1:0]  top_bits;
    n0 = sent;
    b0 = blocks_sent;
    while (sent - n0 < budget || (want_block && blocks_sent == b0)) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (want_block && blocks_sent == b0 &&
          sent - n0 + int'(BLOCK_BYTES) + 40 > budget) begin
        kind = 50;
      end
      if (kind < 40) begin
        repeat ($urandom_range(0, 2)) begin
          sel = $urandom_range(0, 2);
          top_bits = (sel == 0) ? 2'b00 : (sel == 1) ? 2'b10 : 2'b11;
          send(OP_BYTE, {top_bits, 6'($urandom_range(0, 63))});
        end
        idx   = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
        flip7 = ($urandom_range(0, 3) != 0) ? 7'h00 : 7'($urandom_range(1, 127));
        send_frame(idx, $urandom, flip7, $urandom_range(0, 9) != 0, 6);
      end else if (kind < 47) begin
        send_frame(6'($urandom_range(0, 63)), $urandom, 7'h00, 1'b1, $urandom_range(1, 5));
        send(op_e'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
      end else if (kind < 70) begin
        is_multi = 1'($urandom_range(0, 1));
        send(is_multi ? OP_MULTI : OP_SINGLE, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) send(OP_BYTE, TOK_IDLE);
        nblk = is_multi ? $urandom_range(1, 2) : 1;
        live = 1'b1;
        for (int k = 0; k < nblk && live; k++) begin
          flip16 = ($urandom_range(0, 9) < 7) ? 16'h0000 : 16'($urandom_range(1, 65535));
          abort  = (want_block && blocks_sent == b0) ? int'(BLOCK_BYTES) :
                   $urandom_range(0, ABORT_MAX);
          if (is_multi) begin
            send_block(TOK_MULTI, flip16, $urandom_range(0, 3), abort);
          end else begin
            send_block(TOK_SINGLE, flip16, $urandom_range(0, 3), abort);
          end
          if (!is_multi || abort < BLOCK_BYTES || (crc_en && flip16 != 16'h0000)) begin
            live = 1'b0;
          end
        end
        if (live) begin
          send(OP_BYTE, ($urandom_range(0, 4) == 0) ? TOK_SINGLE : TOK_STOP);
        end
      end else if (kind < 80) begin
        send(($urandom_range(0, 1) != 0) ? OP_MULTI : OP_SINGLE, 8'($urandom_range(0, 255)));
        sel = $urandom_range(0, 4);
        case (sel)
          0: send(OP_BYTE, TOK_SINGLE);
          1: send(OP_BYTE, TOK_MULTI);
          2: send(OP_BYTE, TOK_STOP);
          3: send(OP_BYTE, TOK_IDLE);
          default: send(OP_BYTE, 8'($urandom_range(0, 255)));
        endcase
      end else if (kind < 97) begin
        if ($urandom_range(0, 9) < 7) begin
          send(OP_BYTE, 8'($urandom_range(0, 255)));
        end else begin
          send(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else begin
        wait_idle();
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = OP_BYTE;
    in_mosi     = 8'h00;
    cfg_valid   = 1'b0;
    cfg_wdata   = 1'b0;
    sent        = 0;
    blocks_sent = 0;
    crc_en      = 1'b0;
    no_gaps     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_crc_check(1'b0);
    send(OP_BYTE, 8'h00);
    send(OP_CMD, 8'hFF);
    send_frame(6'd0, 32'h0000_0000, 7'h00, 1'b1, 6);
    send_frame(6'd0, 32'h0000_0000, 7'h7F, 1'b1, 6);
    send_frame(6'd63, 32'hFFFF_FFFF, 7'h00, 1'b0, 6);
    send(OP_SINGLE, 8'h00);
    send(OP_BYTE, TOK_IDLE);
    send(OP_BYTE, TOK_STOP);
    send(OP_MULTI, 8'hFF);
    send(OP_BYTE, TOK_SINGLE);

    for (int p = 0; p < 3; p++) begin
      wait_idle();
      set_crc_check(p != 1);
      run_phase((p == 0) ? BLOCK_PHASE_ITEMS : PHASE_ITEMS, p == 0);
    end
    wait_idle();

    $display("covered %0d requests, %0d results checked, %0d command frames",
             sent, checked, frames);
    $display("data blocks with crc match %0d, mismatch %0d, crc checking off and on",
             blocks_ok, blocks_bad);
    if (fail_count == 0) begin
      $display("sd_spi_receive_framer regression: pass");
    end else begin
      $display("sd_spi_receive_framer regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sdrx_pkg.sv
rtl/sd_spi_receive_framer.sv
rtl/sdrx_checker.sv
sim/sdrx_crc_pkg.sv
sim/sdrx_event_scoreboard.sv
sim/sd_spi_receive_framer_test.sv
